// ===== design/qas_pkg.sv =====
// qas_pkg: shared constants for the quicksort array sorter
// no dependencies; used by the sorter top level and the generic ram
package qas_pkg;

    localparam int QAS_DATA_W = 32;
    localparam int QAS_DEPTH  = 64;

endpackage

// ===== design/quicksort_array_sorter.sv =====
// quicksort_array_sorter: loads a set of signed values, sorts them with
// hoare-partition quicksort and streams them out ascending
// depends on qas_pkg and qas_ram (value store and range stack)
//
// usage:
// the slave channel takes one 32-bit signed value per request, one request
// per cycle while loading; tlast marks the final value of the set. values
// beyond DEPTH are dropped, a dropped value with tlast still ends the set.
// after tlast the slave tready goes low while the set is sorted in place in
// the value store ram; pending subranges sit in a second ram used as a stack.
// the sort time is data-dependent: it grows with each popped range,
// scanned element and swap, all bound by the single read port of the value
// store. the sorted run then leaves on the master channel, one store read per
// result, the next read issued only once the result is taken, with tlast
// on the final value. a stalled master side holds the result in the output
// register and the sequencer waits. after the last result is taken the block
// returns to loading. reset empties the set and returns to loading; the rams
// need no clearing.
module quicksort_array_sorter
    import qas_pkg::*;
#(
    parameter int DEPTH = QAS_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [QAS_DATA_W-1:0] i_s_tdata,   // value [31:0]
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [QAS_DATA_W-1:0] o_m_tdata,   // value_res [31:0]
    output logic                  o_m_tlast
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = QAS_DATA_W;

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_INIT  = 14'b00000000000010,
        S_POP   = 14'b00000000000100,
        S_POPW  = 14'b00000000001000,
        S_PIV   = 14'b00000000010000,
        S_JRD   = 14'b00000000100000,
        S_IRD   = 14'b00000001000000,
        S_SWAP1 = 14'b00000010000000,
        S_SWAP2 = 14'b00000100000000,
        S_PUSH1 = 14'b00001000000000,
        S_PUSH2 = 14'b00010000000000,
        S_ORD   = 14'b00100000000000,
        S_OWAIT = 14'b01000000000000,
        S_OSEND = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_top, n_top;
    logic [IW-1:0] r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_j, n_j, r_k, n_k;
    logic signed [DW-1:0] r_piv, n_piv;
    logic [DW-1:0] r_vi, n_vi, r_vj, n_vj, r_odata, n_odata;
    logic r_olast, n_olast, r_ovalid, n_ovalid;

    logic                 v_we;
    logic [IW-1:0]        v_waddr, v_raddr;
    logic [DW-1:0]        v_wdata;
    logic signed [DW-1:0] v_rdata;
    logic                 st_we;
    logic [IW-1:0]        st_raddr;
    logic [2*IW-1:0]      st_wdata, st_rdata;
    logic [CW-1:0]        cnt_m1;

    qas_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(v_waddr),
        .i_wdata(v_wdata),
        .i_raddr(v_raddr),
        .o_rdata(v_rdata)
    );

    qas_ram #(.WIDTH(2 * IW), .DEPTH(DEPTH)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(r_top[IW-1:0]),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    assign cnt_m1     = r_count - CW'(1);
    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_top    = r_top;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_piv    = r_piv;
        n_vi     = r_vi;
        n_vj     = r_vj;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_ovalid = r_ovalid;
        v_we     = 1'b0;
        v_waddr  = r_i;
        v_wdata  = r_vj;
        v_raddr  = r_k;
        st_we    = 1'b0;
        st_wdata = {r_lo, r_j};
        st_raddr = r_top[IW-1:0];
        unique case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    if (r_count < CW'(DEPTH)) begin
                        v_we    = 1'b1;
                        v_waddr = r_count[IW-1:0];
                        v_wdata = i_s_tdata;
                        n_count = r_count + CW'(1);
                    end
                    if (i_s_tlast) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_top = '0;
                if (r_count > CW'(1)) begin
                    st_we    = 1'b1;
                    st_wdata = {IW'(0), cnt_m1[IW-1:0]};
                    n_top    = CW'(1);
                end
                n_state = S_POP;
            end
            S_POP: begin
                if (r_top == '0) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_top    = r_top - CW'(1);
                    st_raddr = n_top[IW-1:0];
                    n_state  = S_POPW;
                end
            end
            S_POPW: begin
                n_lo    = st_rdata[2*IW-1:IW];
                n_hi    = st_rdata[IW-1:0];
                v_raddr = n_lo;
                n_state = S_PIV;
            end
            S_PIV: begin
                n_piv   = v_rdata;
                n_i     = r_lo;
                n_j     = r_hi;
                v_raddr = r_hi;
                n_state = S_JRD;
            end
            S_JRD: begin
                if (r_j > r_lo && r_piv < v_rdata) begin
                    n_j     = r_j - IW'(1);
                    v_raddr = n_j;
                end else begin
                    n_vj    = v_rdata;
                    v_raddr = r_i;
                    n_state = S_IRD;
                end
            end
            S_IRD: begin
                if (r_i < r_hi && v_rdata < r_piv) begin
                    n_i     = r_i + IW'(1);
                    v_raddr = n_i;
                end else begin
                    n_vi = v_rdata;
                    if (r_i < r_j) begin
                        n_state = S_SWAP1;
                    end else begin
                        n_state = S_PUSH1;
                    end
                end
            end
            S_SWAP1: begin
                v_we    = 1'b1;
                v_waddr = r_i;
                v_wdata = r_vj;
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                v_we    = 1'b1;
                v_waddr = r_j;
                v_wdata = r_vi;
                n_j     = r_j - IW'(1);
                n_i     = r_i + IW'(1);
                v_raddr = n_j;
                n_state = S_JRD;
            end
            S_PUSH1: begin
                if (({1'b0, r_j} + (IW+1)'(1) < {1'b0, r_hi}) && (r_top < CW'(DEPTH))) begin
                    st_we    = 1'b1;
                    st_wdata = {r_j + IW'(1), r_hi};
                    n_top    = r_top + CW'(1);
                end
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                if (r_lo < r_j && r_top < CW'(DEPTH)) begin
                    st_we    = 1'b1;
                    st_wdata = {r_lo, r_j};
                    n_top    = r_top + CW'(1);
                end
                n_state = S_POP;
            end
            S_ORD: begin
                v_raddr = r_k;
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                n_odata  = v_rdata;
                n_olast  = (CW'(r_k) == cnt_m1);
                n_ovalid = 1'b1;
                n_state  = S_OSEND;
            end
            S_OSEND: begin
                if (i_m_tready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + IW'(1);
                        v_raddr = n_k;
                        n_state = S_OWAIT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_piv   <= n_piv;
        r_vi    <= n_vi;
        r_vj    <= n_vj;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

endmodule

// ===== design/qas_ram.sv =====
// qas_ram: generic single write port, single read port ram with registered read
// depends on qas_pkg for default sizes
module qas_ram
    import qas_pkg::*;
#(
    parameter int WIDTH = QAS_DATA_W,
    parameter int DEPTH = QAS_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
